/* hw/rtl/nau_pkg.sv */
// ----------------------------------------------------------------------------
// nau_pkg: shared types and constants for the neural activation unit
// Fixed-point format, register map, payload structs and the sigmoid table,
// which is built at elaboration.
// ----------------------------------------------------------------------------
package nau_pkg;

  // Q format of operands and results
  localparam int FRAC_BITS   = 8;
  localparam int SIG_ENTRIES = 256;
  localparam int LOG2N       = $clog2(SIG_ENTRIES);

  localparam int DW  = 16;                      // field width
  localparam int XW  = (FRAC_BITS + 6 > 17) ? FRAC_BITS + 6 : 17;
  localparam int OFW = FRAC_BITS + 4;           // offset into the [-8,8) span
  localparam int RW  = 34;                      // widest intermediate result

  localparam logic signed [XW-1:0] SIG_LO = -(XW'(8) <<< FRAC_BITS);
  localparam logic signed [XW-1:0] SIG_HI = XW'(8) <<< FRAC_BITS;
  localparam logic signed [16:0]   ONE17  = 17'(1) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] ONE_R  = RW'(1) <<< FRAC_BITS;

  // leaky slope 0.01 ~ 41/4096
  localparam logic signed [6:0]    LEAK_NUM   = 7'sd41;
  localparam int                   LEAK_SHIFT = 12;
  localparam logic signed [RW-1:0] LEAK_DERIV =
    RW'(((41 << FRAC_BITS) + (1 << (LEAK_SHIFT - 1))) >> LEAK_SHIFT);

  // configuration port
  localparam int   AW                = 3;
  localparam logic REG_FUNCTION_MODE = 1'b0;

  typedef enum logic {
    MODE_SIGMOID = 1'b0,
    MODE_LEAKY   = 1'b1
  } mode_t;

  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_DERIV   = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic signed [DW-1:0]  operand_value;
    logic                  last_element;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0]  result_value;
    logic                  result_last;
  } result_t;

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at cell midpoints of [-8,8); e^-h by Taylor series in Q32,
  // then powers of it for each midpoint, filling both halves symmetrically.
  function automatic logic [SIG_ENTRIES*16-1:0] build_sig_table();
    logic [SIG_ENTRIES*16-1:0] tbl;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] base;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] one;
    logic [63:0] q;
    int          k_idx;
    tbl  = '0;
    t    = (64'd8 << 32) / SIG_ENTRIES;
    term = 64'd1 << 32;
    base = 64'd1 << 32;
    e    = 64'd1 << 32;
    one  = 64'd1 << FRAC_BITS;
    for (int k = 1; k <= 20; k++) begin
      term = udiv64((term * t) >> 32, 64'(k));
      if (k[0]) begin
        base = base - term;
      end else begin
        base = base + term;
      end
    end
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      if (k > 0) begin
        e = (e * base + (64'd1 << 31)) >> 32;
      end
      if (((SIG_ENTRIES - 1 + k) & 1) == 0) begin
        den   = (64'd1 << 32) + e;
        k_idx = (SIG_ENTRIES - 1 + k) >> 1;
        q     = udiv64((one << 32) + (den >> 1), den);
        tbl[k_idx*16 +: 16] = q[15:0];
        if (k > 0) begin
          k_idx = (SIG_ENTRIES - 1 - k) >> 1;
          q     = udiv64(e * one + (den >> 1), den);
          tbl[k_idx*16 +: 16] = q[15:0];
        end
      end
    end
    return tbl;
  endfunction

  localparam logic [SIG_ENTRIES*16-1:0] SIG_TABLE = build_sig_table();

endpackage

/* hw/rtl/neural_activation_unit.sv */
// ----------------------------------------------------------------------------
// neural_activation_unit: sigmoid / clipped leaky ReLU and derivatives
// Element-wise activation on signed Q8.8 values, one transfer per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and pulse start; the item transfers on any
//   rising edge with start high and busy low. busy is never raised, so a new
//   item can transfer every cycle.
//   Output channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then, it cannot stall the block.
//   Path: input register, then result register, which raises done with the
//   result. Throughput: 1 item per cycle. Results come out in input order.
//   Config: APB register 0 at byte address 0, bit 0 = function_mode
//   (0 sigmoid, 1 clipped leaky ReLU). Write only while no item is in flight.
//   Reset (rst, synchronous): clears the pipeline valid bits and sets the
//   mode to sigmoid. Items in flight at reset are dropped.
//   The sigmoid table is a constant lookup; nothing needs clearing.
// ----------------------------------------------------------------------------
module neural_activation_unit
  import nau_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // command channel
  input  logic          start,
  output logic          busy,
  input  item_t         item,
  // result channel
  output logic          done,
  output result_t       result,
  // APB config port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  mode_t                  mode;
  logic                   s1_valid;
  item_t                  s1_item;

  logic                   cfg_wr;
  logic                   accept;

  logic signed [DW-1:0]   x;
  logic signed [XW-1:0]   xw;
  logic [OFW-1:0]         off;
  logic [OFW+LOG2N-1:0]   off_scaled;
  logic [LOG2N-1:0]       sig_idx;
  logic signed [RW-1:0]   sig_fwd;

  logic signed [16:0]     one_minus_x;
  logic signed [32:0]     sig_prod;
  logic signed [RW-1:0]   sig_der;

  logic signed [16:0]     leak_d;
  logic signed [22:0]     leak_prod;
  logic signed [22:0]     leak_rnd;
  logic                   in_unit;
  logic signed [RW-1:0]   leak_fwd;
  logic signed [RW-1:0]   leak_der;

  logic signed [RW-1:0]   cand;
  logic signed [DW-1:0]   sat_val;

  // Never back-pressured: one item per clock.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // APB: no wait states, single register at index 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_FUNCTION_MODE) ? {31'b0, mode} : 32'b0;

  // --- input register to result register datapath ---
  assign x  = s1_item.operand_value;
  assign xw = XW'(x);

  // Sigmoid forward: index = (x + 8) * N / 16 in table units.
  assign off        = OFW'(xw - SIG_LO);
  assign off_scaled = {off, {LOG2N{1'b0}}};
  assign sig_idx    = off_scaled[OFW+LOG2N-1:OFW];

  always_comb begin
    if (xw < SIG_LO) begin
      sig_fwd = '0;
    end else if (xw >= SIG_HI) begin
      sig_fwd = ONE_R;
    end else begin
      sig_fwd = RW'(SIG_TABLE[{sig_idx, 4'b0} +: 16]);
    end
  end

  // Sigmoid derivative: x*(1-x), rounded half up.
  assign one_minus_x = ONE17 - 17'(x);
  assign sig_prod    = 33'(x) * 33'(one_minus_x);
  assign sig_der     = (RW'(sig_prod) + (RW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  // Leaky ReLU: slope 41/4096 below 0 and above 1, identity between.
  assign in_unit   = (x >= 0) && (17'(x) <= ONE17);
  assign leak_d    = (x < 0) ? 17'(x) : (17'(x) - ONE17);
  assign leak_prod = 23'(leak_d) * 23'(LEAK_NUM);
  assign leak_rnd  = (leak_prod + 23'sd2048) >>> LEAK_SHIFT;

  always_comb begin
    if (x < 0) begin
      leak_fwd = RW'(leak_rnd);
    end else if (in_unit) begin
      leak_fwd = RW'(x);
    end else begin
      leak_fwd = ONE_R + RW'(leak_rnd);
    end
  end

  assign leak_der = in_unit ? ONE_R : LEAK_DERIV;

  always_comb begin
    unique case (mode)
      MODE_SIGMOID: cand = (s1_item.opcode == OP_DERIV) ? sig_der  : sig_fwd;
      MODE_LEAKY:   cand = (s1_item.opcode == OP_DERIV) ? leak_der : leak_fwd;
      default:      cand = sig_fwd;
    endcase
  end

  // Clamp to the 16-bit signed range.
  always_comb begin
    if (cand > RW'(32767)) begin
      sat_val = 16'sh7FFF;
    end else if (cand < -RW'(32768)) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = cand[DW-1:0];
    end
  end

  // Control: valid bits and the mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
      mode     <= MODE_SIGMOID;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid;
      if (cfg_wr && (paddr[2] == REG_FUNCTION_MODE)) begin
        mode <= mode_t'(pwdata[0]);
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    if (s1_valid) begin
      result.result_value <= sat_val;
      result.result_last  <= s1_item.last_element;
    end
  end

endmodule

/* hw/rtl/nau_checker.sv */
// ----------------------------------------------------------------------------
// nau_checker: port-level checks for the neural activation unit
// Watches latency, flag pass-through and register write-back.
// ----------------------------------------------------------------------------
module nau_checker
  import nau_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input item_t         item,
  input logic          done,
  input result_t       result,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [AW-1:0] paddr,
  input logic [31:0]   pwdata,
  input logic [31:0]   prdata,
  input logic          pready
);

  logic in_xfer;
  logic mode_wr;

  assign in_xfer = start && !busy;
  assign mode_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FUNCTION_MODE);

  // every transfer in yields a result through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##2 done)
    else $error("result missing two cycles after input transfer");

  // no result without a transfer in
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |-> ##2 !done)
    else $error("result strobe without matching input transfer");

  // end-of-vector flag follows its item
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##2 (result.result_last == $past(item.last_element, 2)))
    else $error("result_last does not match its item");

  // mode register reads back what was written
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    ($past(mode_wr) && !$past(rst) && (paddr[2] == REG_FUNCTION_MODE))
      |-> (prdata[0] == $past(pwdata[0])))
    else $error("function_mode readback mismatch");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (.*);
